// File: sv/kll_quantile_sketch_core_macros.svh
// ----------------------------------------------------------------------------
// KLL sketch assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KLL_QUANTILE_SKETCH_CORE_MACROS_SVH
`define KLL_QUANTILE_SKETCH_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KLL_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define KLL_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KLL_ASSERT_IMP(label, clk, rstn, ante, cons)
`define KLL_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: sv/kll_pkg.sv
// ----------------------------------------------------------------------------
// KLL sketch package
// Sizes, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package kll_pkg;
    localparam int COMPACTED_LEVELS = 20;
    localparam int NUM_LEVELS       = COMPACTED_LEVELS + 1;
    localparam int CAPACITY_MAX     = 256;
    localparam int SLOTS            = 2 * CAPACITY_MAX;
    localparam int SLOT_W           = $clog2(SLOTS);
    localparam int LVL_W            = $clog2(NUM_LEVELS);
    localparam int FILL_W           = SLOT_W + 1;
    localparam int ADDR_W           = LVL_W + SLOT_W;
    localparam int MEM_DEPTH        = NUM_LEVELS * SLOTS;
    localparam int CAP_W            = 9;
    localparam int CAP_MIN          = 10;
    localparam int CAP_RESET        = 200;
    localparam int VAL_W            = 32;
    localparam int Q_W              = 16;
    localparam int KEY_W            = 2 * VAL_W;
    localparam int CNT_W            = $clog2(MEM_DEPTH + 1);
    localparam int TOT_W            = VAL_W + 2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic accept;
        logic push_sample;
        logic comp_init;
        logic pass_start;
        logic pass_all;
        logic emit;
        logic next_key;
        logic flush;
        logic query_init;
        logic set_target;
        logic add_run;
        logic set_full;
        logic set_empty;
        logic res_min;
        logic res_prev;
        logic load_out;
    } kll_cmd_t;

    typedef struct packed {
        logic refuse;
        logic l0_over;
        logic cascade;
        logic pass_done;
        logic found;
        logic any;
        logic emit_last;
        logic run_hit;
    } kll_stat_t;
endpackage

// File: sv/kll_ctrl.sv
// ----------------------------------------------------------------------------
// KLL sketch controller
// Sequences updates, level compaction and quantile queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module kll_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_func,
    input  logic             m_tready,
    input  kll_pkg::kll_stat_t stat,
    output kll_pkg::kll_cmd_t  cmd,
    output logic             s_tready,
    output logic             m_tvalid
);
    import kll_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UPD    = 4'd1;
    localparam logic [3:0] S_CHK    = 4'd2;
    localparam logic [3:0] S_CSTART = 4'd3;
    localparam logic [3:0] S_CSCAN  = 4'd4;
    localparam logic [3:0] S_EMIT   = 4'd5;
    localparam logic [3:0] S_FLUSH  = 4'd6;
    localparam logic [3:0] S_CASC   = 4'd7;
    localparam logic [3:0] S_QSTART = 4'd8;
    localparam logic [3:0] S_QTOT   = 4'd9;
    localparam logic [3:0] S_TGT    = 4'd10;
    localparam logic [3:0] S_QPASS  = 4'd11;
    localparam logic [3:0] S_QSCAN  = 4'd12;
    localparam logic [3:0] S_RESP   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = s_func ? S_QSTART : S_UPD;
                end
            end
            S_UPD: begin
                if (stat.refuse) begin
                    cmd.set_full = 1'b1;
                    state_next   = S_RESP;
                end else begin
                    cmd.push_sample = 1'b1;
                    state_next      = S_CHK;
                end
            end
            S_CHK: begin
                if (stat.l0_over) begin
                    cmd.comp_init = 1'b1;
                    state_next    = S_CSTART;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_CSTART: begin
                cmd.pass_start = 1'b1;
                state_next     = S_CSCAN;
            end
            S_CSCAN: begin
                if (stat.pass_done) state_next = stat.found ? S_EMIT : S_FLUSH;
            end
            S_EMIT: begin
                cmd.emit = 1'b1;
                if (stat.emit_last) begin
                    cmd.next_key = 1'b1;
                    state_next   = S_CSTART;
                end
            end
            S_FLUSH: begin
                cmd.flush  = 1'b1;
                state_next = S_CASC;
            end
            S_CASC: begin
                state_next = stat.cascade ? S_CSTART : S_RESP;
            end
            S_QSTART: begin
                cmd.query_init = 1'b1;
                cmd.pass_start = 1'b1;
                cmd.pass_all   = 1'b1;
                state_next     = S_QTOT;
            end
            S_QTOT: begin
                if (stat.pass_done) begin
                    if (stat.any) begin
                        state_next = S_TGT;
                    end else begin
                        cmd.set_empty = 1'b1;
                        state_next    = S_RESP;
                    end
                end
            end
            S_TGT: begin
                cmd.set_target = 1'b1;
                state_next     = S_QPASS;
            end
            S_QPASS: begin
                cmd.pass_start = 1'b1;
                cmd.pass_all   = 1'b1;
                state_next     = S_QSCAN;
            end
            S_QSCAN: begin
                if (stat.pass_done) begin
                    if (!stat.found) begin
                        cmd.res_prev = 1'b1;
                        state_next   = S_RESP;
                    end else if (stat.run_hit) begin
                        cmd.res_min = 1'b1;
                        state_next  = S_RESP;
                    end else begin
                        cmd.add_run  = 1'b1;
                        cmd.next_key = 1'b1;
                        state_next   = S_QPASS;
                    end
                end
            end
            S_RESP: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.load_out) mvalid_next = 1'b1;
        else if (m_tready) mvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;
endmodule

// File: sv/kll_dpath.sv
// ----------------------------------------------------------------------------
// KLL sketch datapath
// Level memory, fill counts, min-key scan, merge and query arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module kll_dpath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  kll_pkg::kll_cmd_t              cmd,
    output kll_pkg::kll_stat_t             stat,
    input  logic                           cfg_we,
    input  logic [kll_pkg::CAP_W-1:0]      cfg_wdata,
    input  logic [kll_pkg::VAL_W-1:0]      in_sample,
    input  logic [kll_pkg::Q_W-1:0]        in_q,
    output logic [kll_pkg::CAP_W-1:0]      eff_cap,
    output logic [2*kll_pkg::VAL_W-1:0]    out_data,
    output logic [1:0]                     out_status
);
    import kll_pkg::*;

    localparam logic [VAL_W-1:0] SIGN_BIT = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [LVL_W-1:0] TOP_LVL  = LVL_W'(COMPACTED_LEVELS);

    logic [KEY_W-1:0]  mem [0:MEM_DEPTH-1];
    logic [KEY_W-1:0]  rd_data_reg;
    logic              rd_v_reg;
    logic [FILL_W-1:0] fill_reg [NUM_LEVELS];

    logic [CAP_W-1:0]  cap_reg;
    logic [VAL_W-1:0]  sample_reg;
    logic [Q_W-1:0]    q_reg;
    logic [VAL_W-1:0]  count_reg;
    logic [VAL_W-1:0]  result_reg;
    logic [1:0]        status_reg;
    logic [2*VAL_W-1:0] out_data_reg;
    logic [1:0]        out_status_reg;

    logic [LVL_W-1:0]  cur_lvl_reg;
    logic [LVL_W-1:0]  scan_lvl_reg, scan_hi_reg;
    logic [FILL_W-1:0] scan_idx_reg;
    logic              scanning_reg;

    logic [KEY_W-1:0]  prev_key_reg, min_key_reg, pend_key_reg;
    logic              have_prev_reg, found_reg, any_reg, pend_v_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TOT_W-1:0]  wsum_reg, total_reg, run_reg, target_reg;

    // effective capacity
    always_comb begin
        if (cap_reg < CAP_W'(CAP_MIN)) eff_cap = CAP_W'(CAP_MIN);
        else if (cap_reg > CAP_W'(CAPACITY_MAX)) eff_cap = CAP_W'(CAPACITY_MAX);
        else eff_cap = cap_reg;
    end

    // scan address side
    logic              scan_issue;
    logic [ADDR_W-1:0] rd_addr;
    assign scan_issue = scanning_reg && (scan_idx_reg < fill_reg[scan_lvl_reg]);
    assign rd_addr    = {scan_lvl_reg, scan_idx_reg[SLOT_W-1:0]};

    // key on the read port
    logic [KEY_W-1:0]  rd_key;
    logic [VAL_W-1:0]  rd_w;
    logic              key_gt_prev;
    assign rd_key      = {rd_data_reg[KEY_W-1:VAL_W] ^ SIGN_BIT, rd_data_reg[VAL_W-1:0]};
    assign rd_w        = rd_data_reg[VAL_W-1:0];
    assign key_gt_prev = !have_prev_reg || (rd_key > prev_key_reg);

    // push port (update sample or merged item)
    logic              push_en;
    logic [LVL_W-1:0]  push_lvl;
    logic [VAL_W-1:0]  push_v, push_w;
    logic [VAL_W-1:0]  min_v, pend_v;
    logic [FILL_W-1:0] push_fill;

    assign min_v = min_key_reg[KEY_W-1:VAL_W] ^ SIGN_BIT;
    assign pend_v = pend_key_reg[KEY_W-1:VAL_W] ^ SIGN_BIT;

    always_comb begin
        push_en  = 1'b0;
        push_lvl = cur_lvl_reg + LVL_W'(1);
        push_v   = min_v;
        push_w   = min_key_reg[VAL_W-1:0];
        if (cmd.push_sample) begin
            push_en  = 1'b1;
            push_lvl = '0;
            push_v   = sample_reg;
            push_w   = VAL_W'(1);
        end else if (cmd.emit && pend_v_reg) begin
            // even levels keep the lower value of a pair, odd levels the upper
            push_en = 1'b1;
            push_v  = cur_lvl_reg[0] ? min_v : pend_v;
            push_w  = pend_key_reg[VAL_W-1:0] + min_key_reg[VAL_W-1:0];
        end else if (cmd.flush && pend_v_reg) begin
            push_en = 1'b1;
            push_v  = pend_v;
            push_w  = pend_key_reg[VAL_W-1:0];
        end
    end
    assign push_fill = fill_reg[push_lvl];

    logic             push_ok;
    logic [ADDR_W-1:0] wr_addr;
    assign push_ok = push_en && (push_fill < FILL_W'(SLOTS));
    assign wr_addr = {push_lvl, push_fill[SLOT_W-1:0]};

    always_ff @(posedge aclk) begin
        if (push_ok) mem[wr_addr] <= {push_v, push_w};
        rd_data_reg <= mem[rd_addr];
    end

    // query arithmetic
    logic [Q_W+TOT_W-1:0] prod;
    logic [TOT_W-1:0]     run_sum;
    assign prod    = {{TOT_W{1'b0}}, q_reg} * {{Q_W{1'b0}}, total_reg};
    assign run_sum = run_reg + wsum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_W'(CAP_RESET);
            count_reg     <= '0;
            scanning_reg  <= 1'b0;
            rd_v_reg      <= 1'b0;
            cur_lvl_reg   <= '0;
            for (int i = 0; i < NUM_LEVELS; i++) fill_reg[i] <= '0;
        end else begin
            if (cfg_we) cap_reg <= cfg_wdata;
            if (cmd.push_sample) count_reg <= count_reg + VAL_W'(1);
            if (push_ok) fill_reg[push_lvl] <= push_fill + FILL_W'(1);
            if (cmd.flush) begin
                fill_reg[cur_lvl_reg] <= '0;
                cur_lvl_reg           <= cur_lvl_reg + LVL_W'(1);
            end
            if (cmd.comp_init) cur_lvl_reg <= '0;

            rd_v_reg <= scan_issue;
            if (cmd.pass_start) begin
                scanning_reg <= 1'b1;
                scan_idx_reg <= '0;
                scan_lvl_reg <= cmd.pass_all ? '0 : cur_lvl_reg;
                scan_hi_reg  <= cmd.pass_all ? TOP_LVL : cur_lvl_reg;
            end else if (scanning_reg) begin
                if (scan_issue) begin
                    scan_idx_reg <= scan_idx_reg + FILL_W'(1);
                end else if (scan_lvl_reg == scan_hi_reg) begin
                    scanning_reg <= 1'b0;
                end else begin
                    scan_lvl_reg <= scan_lvl_reg + LVL_W'(1);
                    scan_idx_reg <= '0;
                end
            end
        end
    end

    // pass accumulators and merge/query registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= in_sample;
            q_reg      <= in_q;
            result_reg <= '0;
            status_reg <= STATUS_OK;
        end
        if (cmd.pass_start) begin
            found_reg <= 1'b0;
            any_reg   <= 1'b0;
            total_reg <= '0;
        end else if (rd_v_reg) begin
            any_reg   <= 1'b1;
            total_reg <= total_reg + TOT_W'(rd_w);
            if (key_gt_prev) begin
                if (!found_reg || rd_key < min_key_reg) begin
                    found_reg   <= 1'b1;
                    min_key_reg <= rd_key;
                    cnt_reg     <= CNT_W'(1);
                    wsum_reg    <= TOT_W'(rd_w);
                end else if (rd_key == min_key_reg) begin
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    wsum_reg <= wsum_reg + TOT_W'(rd_w);
                end
            end
        end
        if (cmd.emit) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (pend_v_reg) begin
                pend_v_reg <= 1'b0;
            end else begin
                pend_v_reg   <= 1'b1;
                pend_key_reg <= min_key_reg;
            end
        end
        if (cmd.comp_init || cmd.flush || cmd.query_init) begin
            have_prev_reg <= 1'b0;
            pend_v_reg    <= 1'b0;
        end
        if (cmd.next_key) begin
            have_prev_reg <= 1'b1;
            prev_key_reg  <= min_key_reg;
        end
        if (cmd.query_init) run_reg <= '0;
        if (cmd.add_run) run_reg <= run_sum;
        if (cmd.set_target) target_reg <= prod[Q_W+TOT_W-1:Q_W];
        if (cmd.set_full) status_reg <= STATUS_FULL;
        if (cmd.set_empty) status_reg <= STATUS_EMPTY;
        if (cmd.res_min) result_reg <= min_v;
        if (cmd.res_prev) result_reg <= prev_key_reg[KEY_W-1:VAL_W] ^ SIGN_BIT;
        if (cmd.load_out) begin
            out_data_reg   <= {count_reg, result_reg};
            out_status_reg <= status_reg;
        end
    end

    assign stat.refuse    = (fill_reg[TOP_LVL] > FILL_W'(eff_cap)) || (&count_reg);
    assign stat.l0_over   = fill_reg[0] > FILL_W'(eff_cap);
    assign stat.cascade   = (cur_lvl_reg < TOP_LVL) && (fill_reg[cur_lvl_reg] > FILL_W'(eff_cap));
    assign stat.pass_done = !scanning_reg && !rd_v_reg;
    assign stat.found     = found_reg;
    assign stat.any       = any_reg;
    assign stat.emit_last = cnt_reg == CNT_W'(1);
    assign stat.run_hit   = run_sum >= target_reg;

    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;
endmodule

// File: sv/kll_quantile_sketch_core.sv
// ----------------------------------------------------------------------------
// KLL quantile sketch core
// Streaming approximate-quantile sketch with deterministic level compaction.
// ----------------------------------------------------------------------------
// One item at a time. An update that does not overflow level 0 passes through
// the update and check states before the output handoff. Compaction of a level
// of n items with d distinct keys runs d+1 min-key scan passes, their length set
// by the single read port of the level memory: every pass reads the whole level
// once. A query over N stored items with d distinct keys runs a totalling pass,
// then up to d scan passes over all N items. Results are held in an output
// register so the next item is taken while a result waits. The level memory
// has no reset pass; only entries below each level's fill count are ever read.
`timescale 1ns / 1ps
`include "kll_quantile_sketch_core_macros.svh"
module kll_quantile_sketch_core (
    input  logic        aclk,
    input  logic        aresetn,
    // capacity register write
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // sample_value[31:0], quantile_fraction[47:32]
    input  logic [0:0]  s_tuser,   // func: 0 update, 1 query
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // quantile_value[31:0], items_seen[63:32]
    output logic [1:0]  m_tuser    // status
);
    import kll_pkg::*;

    kll_cmd_t         cmd;
    kll_stat_t        stat;
    logic [CAP_W-1:0] eff_cap;

    // controller: one state machine walks update, compaction cascade, query
    kll_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_func   (s_tuser[0]),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    // datapath: level memory, fills, scan and merge logic
    kll_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_sample  (s_tdata[VAL_W-1:0]),
        .in_q       (s_tdata[VAL_W+Q_W-1:VAL_W]),
        .eff_cap    (eff_cap),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );

    // empty-sketch result carries a zero value
    `KLL_ASSERT_IMP(a_empty_zero, aclk, aresetn, m_tvalid && (m_tuser == STATUS_EMPTY),
        m_tdata[31:0] == 32'd0)
    // capacity always clamped into range
    `KLL_ASSERT_IMP(a_cap_range, aclk, aresetn, 1'b1,
        (eff_cap >= CAP_W'(CAP_MIN)) && (eff_cap <= CAP_W'(CAPACITY_MAX)))
    // after a transfer in, the core is busy
    `KLL_ASSERT_NXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)
endmodule

// File: verif/tb_kll_defs_pkg.sv
// ----------------------------------------------------------------------------
// KLL sketch testbench definitions
// Operation codes shared by the stimulus top and the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tb_kll_defs_pkg;
    typedef enum logic [0:0] {
        OP_UPDATE = 1'b0,
        OP_QUERY  = 1'b1
    } sketch_op_e;
endpackage

// File: verif/kll_sketch_checker.sv
// ----------------------------------------------------------------------------
// KLL sketch checker
// Mirrors the sketch levels from observed transfers and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module kll_sketch_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          errors,
    output int          pending
);
    import kll_pkg::*;
    import tb_kll_defs_pkg::*;

    typedef struct {
        logic [31:0] quant;
        logic [31:0] seen;
        logic [1:0]  status;
    } sketch_result_t;

    sketch_result_t awaited_results[$];

    logic [31:0] lvl_val [NUM_LEVELS][SLOTS];
    logic [31:0] lvl_wt  [NUM_LEVELS][SLOTS];
    int          lvl_fill[NUM_LEVELS];
    logic [31:0] inserted;
    logic [8:0]  cap_reg;
    logic [63:0] kbuf[MEM_DEPTH];

    assign pending = awaited_results.size();

    function automatic int cap_eff();
        if (cap_reg < CAP_MIN) return CAP_MIN;
        if (cap_reg > CAPACITY_MAX) return CAPACITY_MAX;
        return int'(cap_reg);
    endfunction

    // signed value order first, weight breaks ties
    task automatic sort_keys(input int n);
        logic [63:0] k;
        int j;
        for (int i = 1; i < n; i++) begin
            k = kbuf[i];
            j = i - 1;
            while (j >= 0 && kbuf[j] > k) begin
                kbuf[j + 1] = kbuf[j];
                j--;
            end
            kbuf[j + 1] = k;
        end
    endtask

    task automatic push_item(input int l, input logic [31:0] v, input logic [31:0] w);
        if (lvl_fill[l] < SLOTS) begin
            lvl_val[l][lvl_fill[l]] = v;
            lvl_wt[l][lvl_fill[l]]  = w;
            lvl_fill[l]++;
        end
    endtask

    task automatic fold_level(input int l);
        int n;
        logic [31:0] v, w;
        n = lvl_fill[l];
        for (int i = 0; i < n; i++) kbuf[i] = {lvl_val[l][i] ^ 32'h8000_0000, lvl_wt[l][i]};
        sort_keys(n);
        for (int i = 0; i + 1 < n; i += 2) begin
            w = kbuf[i][31:0] + kbuf[i + 1][31:0];
            v = (l % 2 == 0) ? kbuf[i][63:32] : kbuf[i + 1][63:32];
            push_item(l + 1, v ^ 32'h8000_0000, w);
        end
        if (n % 2 == 1) push_item(l + 1, kbuf[n - 1][63:32] ^ 32'h8000_0000, kbuf[n - 1][31:0]);
        lvl_fill[l] = 0;
    endtask

    task automatic predict_sketch(input sketch_op_e op, input logic [31:0] sample,
                                  input logic [15:0] frac);
        sketch_result_t r;
        int n, k, l;
        logic [63:0] total, target, run;
        r.quant  = '0;
        r.status = STATUS_OK;
        k = cap_eff();
        if (op == OP_UPDATE) begin
            if (lvl_fill[COMPACTED_LEVELS] > k || inserted == 32'hFFFF_FFFF) begin
                r.status = STATUS_FULL;
            end else begin
                push_item(0, sample, 32'd1);
                inserted++;
                if (lvl_fill[0] > k) begin
                    l = 0;
                    do begin
                        fold_level(l);
                        l++;
                    end while (l < COMPACTED_LEVELS && lvl_fill[l] > k);
                end
            end
        end else begin
            n = 0;
            total = '0;
            for (int lv = 0; lv < NUM_LEVELS; lv++) begin
                for (int i = 0; i < lvl_fill[lv]; i++) begin
                    kbuf[n] = {lvl_val[lv][i] ^ 32'h8000_0000, lvl_wt[lv][i]};
                    total += lvl_wt[lv][i];
                    n++;
                end
            end
            if (n == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                sort_keys(n);
                target = (64'(frac) * total) >> 16;
                run = '0;
                r.quant = kbuf[n - 1][63:32] ^ 32'h8000_0000;
                for (int i = 0; i < n; i++) begin
                    run += kbuf[i][31:0];
                    if (run >= target) begin
                        r.quant = kbuf[i][63:32] ^ 32'h8000_0000;
                        break;
                    end
                end
            end
        end
        r.seen = inserted;
        awaited_results.insert(awaited_results.size(), r);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] mismatch %s: got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge aclk) begin
        sketch_result_t e;
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEVELS; i++) lvl_fill[i] = 0;
            inserted = '0;
            cap_reg = 9'(CAP_RESET);
            awaited_results.delete();
        end else begin
            if (cfg_we) cap_reg = cfg_wdata;
            if (s_tvalid && s_tready)
                predict_sketch(sketch_op_e'(s_tuser[0]), s_tdata[31:0], s_tdata[47:32]);
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    report("unexpected result transfer", m_tdata[31:0], '0);
                end else begin
                    e = awaited_results.pop_front();
                    if (m_tdata[31:0] !== e.quant) report("quantile_value", m_tdata[31:0], e.quant);
                    if (m_tdata[63:32] !== e.seen) report("items_seen", m_tdata[63:32], e.seen);
                    if (m_tuser !== e.status) report("status", 32'(m_tuser), 32'(e.status));
                end
            end
        end
    end
endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// KLL quantile sketch testbench
// Directed corner items, then randomized update/query traffic over several
// capacity settings with random backpressure; the checker scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
    import kll_pkg::*;
    import tb_kll_defs_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int LONG_HOLD   = 3000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [8:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    int          errors, pending;

    int          cycles = 0;
    int          n_updates = 0, n_queries = 0, n_cfg = 0;
    bit          hold_req = 1'b0;      // asks the receiver for one long hold-off
    bit          burst_mode = 1'b0;    // no idling on either side while set
    logic [31:0] value_pool[24];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    kll_quantile_sketch_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    kll_sketch_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls, plus the one long hold-off on request
    int stall_left = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready = 1'b0;
        end else if (hold_req) begin
            m_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge aclk);
            hold_req = 1'b0;
            m_tready = 1'b1;
        end else if (stall_left > 0 && !burst_mode) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = idle_len();
        end
    end

    // one input transfer; tready is read mid-low-phase, well after it settles
    task automatic send_item(input sketch_op_e op, input logic [31:0] sample,
                             input logic [15:0] frac);
        bit taken;
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {frac, sample};
        do begin
            #0.5 taken = s_tready;
            @(posedge aclk);
            @(negedge aclk);
        end while (!taken);
        if (op == OP_UPDATE) n_updates++;
        else n_queries++;
        if (!burst_mode) begin
            int gap;
            gap = idle_len();
            if (gap > 0) begin
                s_tvalid = 1'b0;
                s_tdata  = 48'({$urandom, $urandom});
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge aclk);
    endtask

    // idle-only register write
    task automatic set_capacity(input logic [8:0] cap);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = cap;
        @(negedge aclk);
        cfg_we    = 1'b0;
        n_cfg++;
    endtask

    // Values come mostly from a small per-phase pool so queries see few
    // distinct keys and stay fast; a share is fully random.
    task automatic refill_pool();
        foreach (value_pool[i]) value_pool[i] = $urandom;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, 23)];
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_frac();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic random_phase(input int n_items, input int query_pct, input bit with_hold);
        refill_pool();
        for (int i = 0; i < n_items; i++) begin
            if (i % 64 == 0) burst_mode = ($urandom_range(0, 4) == 0);
            if (with_hold && i == 40) hold_req = 1'b1;    // sender keeps offering
            if (i == n_items / 2) wait_drained();          // sender pauses to empty
            if ($urandom_range(0, 99) < query_pct)
                send_item(OP_QUERY, $urandom, pick_frac());
            else
                send_item(OP_UPDATE, pick_value(), 16'($urandom));
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty queries, extreme values, ties, quantile extremes
        send_item(OP_QUERY, 32'h0, 16'h0000);
        send_item(OP_QUERY, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_UPDATE, 32'h8000_0000, 16'hFFFF);
        send_item(OP_UPDATE, 32'h7FFF_FFFF, 16'h0000);
        send_item(OP_UPDATE, 32'h0000_0000, 16'h0000);
        send_item(OP_UPDATE, 32'hFFFF_FFFF, 16'h0000);
        send_item(OP_UPDATE, 32'h0000_0001, 16'h0000);
        send_item(OP_UPDATE, 32'h0000_0001, 16'h0000);
        send_item(OP_QUERY, 32'h0, 16'h0000);
        send_item(OP_QUERY, 32'h0, 16'hFFFF);
        send_item(OP_QUERY, 32'h0, 16'h8000);
        send_item(OP_QUERY, 32'h0, 16'h0001);
        send_item(OP_QUERY, 32'h0, 16'h5555);
        send_item(OP_QUERY, 32'h0, 16'hAAAA);

        // below the minimum: clamps to the smallest capacity, deep cascades
        set_capacity(9'd0);
        for (int i = 0; i < 14; i++) send_item(OP_UPDATE, 32'(i % 3) - 32'd1, 16'h0);
        send_item(OP_QUERY, 32'h0, 16'h4000);
        random_phase(420, 8, 1'b1);

        // above the maximum: clamps to the largest capacity
        set_capacity(9'h1FF);
        random_phase(150, 6, 1'b0);

        // lowered with a full level 0: compaction on the next update
        set_capacity(9'd12);
        random_phase(300, 8, 1'b0);

        set_capacity(9'd137);
        random_phase(130, 6, 1'b0);

        wait_drained();
        repeat (100) @(negedge aclk);

        $display("covered %0d updates and %0d queries over %0d capacity writes",
                 n_updates, n_queries, n_cfg);
        $display("clamped, lowered and mid-range capacities with random backpressure");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+sv
sv/kll_pkg.sv
sv/kll_ctrl.sv
sv/kll_dpath.sv
sv/kll_quantile_sketch_core.sv
verif/tb_kll_defs_pkg.sv
verif/kll_sketch_checker.sv
verif/tb_top.sv
